FILE: src/bea_pkg.sv
// Shared types, codes and constants of the band energy autocorrelator.
package bea_pkg;

    localparam int DEF_DEPTH     = 32;
    localparam int DEF_FRAC_BITS = 6;
    localparam int NORM_BITS     = 20;
    localparam int SLOT_W        = 6;
    localparam int ENERGY_W      = 32;
    localparam int FREQ_W        = 16;
    localparam int MAG_W         = 16;
    localparam int LEN_W         = 7;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int CORR_W        = 16;
    localparam int CORR_FRAC     = 15;
    localparam int LAG_W         = 6;

    localparam logic [1:0] KIND_BIN   = 2'd0;
    localparam logic [1:0] KIND_REQ   = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    localparam logic [1:0] BAND_RED   = 2'd0;
    localparam logic [1:0] BAND_GREEN = 2'd1;

    localparam logic [CFG_IDX_W-1:0] REG_RED_LO   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RED_HI   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_LO = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_HI = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_LO  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_HI  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ACT_LEN  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_FRM  = 3'd7;

    typedef struct packed {
        logic [1:0]        kind;
        logic [FREQ_W-1:0] bin_frequency;
        logic [MAG_W-1:0]  bin_magnitude;
        logic              last_bin;
        logic [1:0]        band_select;
    } t_in_item;

    typedef struct packed {
        logic [LAG_W-1:0]         lag_index;
        logic signed [CORR_W-1:0] correlation;
        logic                     last_lag;
        logic                     history_ready;
        logic                     flat_signal;
    } t_out_item;

    typedef struct packed {
        logic [ENERGY_W-1:0] red;
        logic [ENERGY_W-1:0] green;
        logic [ENERGY_W-1:0] blue;
    } t_energy;

    typedef struct packed {
        logic [SLOT_W-1:0] rd_addr;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        t_energy           wr_data;
        logic              inval_en;
        logic [SLOT_W-1:0] inval_addr;
        logic              clear_all;
    } t_ring_ctl;

endpackage

FILE: src/bea_divider.sv
// Shared restoring divider, one quotient bit per cycle.
module bea_divider #(
    parameter int DDW = 64,
    parameter int DSW = 48
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [DDW-1:0] i_dividend,
    input  logic [DSW-1:0] i_divisor,
    output logic           o_done,
    output logic [DDW-1:0] o_quotient
);
    localparam int CW = $clog2(DDW + 1);

    logic           r_busy;
    logic           r_done;
    logic [CW-1:0]  r_cnt;
    logic [DSW-1:0] r_rem;
    logic [DSW-1:0] r_dsor;
    logic [DDW-1:0] r_quo;
    logic [DSW:0]   rem_sh;
    logic           fits;

    assign rem_sh = {r_rem, r_quo[DDW-1]};
    assign fits   = rem_sh >= {1'b0, r_dsor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DDW - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_dsor <= i_divisor;
            r_quo  <= i_dividend;
        end else if (r_busy) begin
            r_rem <= fits ? DSW'(rem_sh - {1'b0, r_dsor}) : DSW'(rem_sh);
            r_quo <= {r_quo[DDW-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: src/bea_ring.sv
// Ring of per-frame band energies with per-slot valid bits.
module bea_ring
#(
    parameter int DEPTH = bea_pkg::DEF_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bea_pkg::t_ring_ctl i_ctl,
    output bea_pkg::t_energy   o_rd_data
);
    import bea_pkg::*;

    localparam int AW = $clog2(DEPTH);

    t_energy          r_mem [DEPTH];
    t_energy          r_rd;
    logic             r_rd_valid;
    logic [DEPTH-1:0] r_valid;
    logic [DEPTH-1:0] n_valid;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_ctl.wr_addr[AW-1:0]] <= i_ctl.wr_data;
        end
        r_rd <= r_mem[i_ctl.rd_addr[AW-1:0]];
    end

    always_comb begin
        n_valid = r_valid;
        if (i_ctl.clear_all) begin
            n_valid = '0;
        end else begin
            if (i_ctl.wr_en) begin
                n_valid[i_ctl.wr_addr[AW-1:0]] = 1'b1;
            end
            if (i_ctl.inval_en) begin
                n_valid[i_ctl.inval_addr[AW-1:0]] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_valid    <= n_valid;
            r_rd_valid <= r_valid[i_ctl.rd_addr[AW-1:0]];
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd : '0;

endmodule

FILE: src/band_energy_autocorrelator.sv
// Band energy autocorrelator: top level with sequencer, history buffers and shared MAC.
//
// A spectrum bin transaction reads the ring on acceptance, then writes back in S_BIN; a clear or an
// unknown kind completes at acceptance. A request with too few frames gives its single result in the
// cycle after acceptance. A full request with L lags and a D-bit divider (D = 64 at defaults) runs a
// history load, a mean division, centering, a scale search, L(L+1)/2 multiply-accumulates on the
// single multiplier and, unless the history is flat, L normalizing divisions on the bit-serial divider.
// busy stays high meanwhile. Results come one per strobe and cannot be held off; ring history resets
// through per-slot valid bits, so no clearing pass follows reset.
module band_energy_autocorrelator #(
    parameter int DEPTH     = bea_pkg::DEF_DEPTH,
    parameter int FRAC_BITS = bea_pkg::DEF_FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  bea_pkg::t_in_item                   i_item,
    output logic                                o_result_valid,
    output bea_pkg::t_out_item                  o_result,
    input  logic                                i_cfg_we,
    input  logic [bea_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [bea_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);
    import bea_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);
    localparam int MW   = ENERGY_W + FRAC_BITS;
    localparam int CW   = MW + 1;
    localparam int SUMW = ENERGY_W + CNTW;
    localparam int SW   = $clog2(MW + 1);
    localparam int PW   = NORM_BITS + 1;
    localparam int LW   = 2 * PW + CNTW;
    localparam int DDW  = (LW + CORR_FRAC + 1 > SUMW + FRAC_BITS) ?
                          LW + CORR_FRAC + 1 : SUMW + FRAC_BITS;

    localparam logic [1:0] PH_ADDR = 2'd0;
    localparam logic [1:0] PH_DATA = 2'd1;
    localparam logic [1:0] PH_MUL  = 2'd2;
    localparam logic [1:0] PH_ACC  = 2'd3;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_BIN   = 8'b00000010,
        S_LOAD  = 8'b00000100,
        S_MEAN  = 8'b00001000,
        S_CENT  = 8'b00010000,
        S_SHIFT = 8'b00100000,
        S_MAC   = 8'b01000000,
        S_OUT   = 8'b10000000
    } t_state;

    function automatic logic [ENERGY_W-1:0] sat_add(input logic [ENERGY_W-1:0] a,
                                                    input logic [MAG_W-1:0] b);
        logic [ENERGY_W:0] s;
        s = {1'b0, a} + (ENERGY_W + 1)'(b);
        return s[ENERGY_W] ? '1 : s[ENERGY_W-1:0];
    endfunction

    function automatic logic in_band(input logic [FREQ_W-1:0] f,
                                     input logic [FREQ_W-1:0] lo,
                                     input logic [FREQ_W-1:0] hi);
        return (f >= lo) && (f <= hi);
    endfunction

    function automatic logic signed [PW-1:0] scale(input logic signed [CW-1:0] v,
                                                   input logic [SW-1:0] sh);
        logic [CW-1:0] mag;
        logic [CW-1:0] sm;
        logic [PW-1:0] m;
        mag = v[CW-1] ? CW'(-v) : CW'(v);
        sm  = mag >> sh;
        m   = PW'(sm);
        return v[CW-1] ? PW'({PW{1'b0}} - m) : m;
    endfunction

    // configuration
    logic [FREQ_W-1:0] r_red_lo, r_red_hi, r_green_lo, r_green_hi, r_blue_lo, r_blue_hi;
    logic [LEN_W-1:0]  r_active_length, r_min_frames;

    // control
    t_state            r_state, n_state;
    logic [1:0]        r_ph, n_ph;
    logic [AW-1:0]     r_i, n_i, r_k, n_k, r_s, n_s, r_p, n_p;
    logic [CNTW-1:0]   r_len, n_len, r_n, n_n;
    logic [1:0]        r_band, n_band;
    logic [AW-1:0]     r_write_slot, n_write_slot;
    logic [CNTW-1:0]   r_frame_count, n_frame_count;
    logic              r_out_valid, n_out_valid;

    // datapath
    t_in_item          r_item, n_item;
    logic [SUMW-1:0]   r_sum, n_sum;
    logic [MW-1:0]     r_mean, n_mean;
    logic [MW-1:0]     r_maxmag, n_maxmag;
    logic [MW-1:0]     r_mag, n_mag;
    logic [SW-1:0]     r_sh, n_sh;
    logic signed [PW-1:0]   r_a, n_a, r_b, n_b;
    logic signed [2*PW-1:0] r_prod, n_prod;
    logic signed [LW-1:0]   r_acc, n_acc, r_best, n_best;
    t_out_item         r_out, n_out;

    // memories
    logic signed [CW-1:0] r_cb [DEPTH];
    logic signed [CW-1:0] r_cb_a, r_cb_b;
    logic signed [LW-1:0] r_lag [DEPTH];
    logic signed [LW-1:0] r_lag_rd;
    logic                 cb_we;
    logic signed [CW-1:0] cb_wdata;
    logic                 lag_we;

    // ring and divider
    t_ring_ctl         ring_ctl;
    t_energy           ring_rd;
    t_energy           bin_upd;
    logic              div_start;
    logic [DDW-1:0]    div_dividend;
    logic [LW-1:0]     div_divisor;
    logic              div_done;
    logic [DDW-1:0]    div_quo;

    // derived
    logic              accept;
    logic [CNTW-1:0]   len_now, n_now;
    logic [AW-1:0]     cur_p, s0, p_next;
    logic [LEN_W-1:0]  need;
    logic [CNTW:0]     s_tmp;
    logic [ENERGY_W-1:0] band_x;
    logic [MW-1:0]     xs;
    logic signed [CW-1:0] cval;
    logic [MW-1:0]     cmag;
    logic signed [LW-1:0] mac_sum;
    logic [LW-1:0]     lmag;
    logic              flat;
    logic              i_last, k_last, mac_last;
    logic [AW-1:0]     s_next;
    logic signed [CORR_W-1:0] qval;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    always_comb begin
        if (r_active_length < LEN_W'(2)) begin
            len_now = CNTW'(2);
        end else if ((LEN_W + 1)'(r_active_length) > (LEN_W + 1)'(DEPTH)) begin
            len_now = CNTW'(DEPTH);
        end else begin
            len_now = CNTW'(r_active_length);
        end
    end

    assign cur_p = (CNTW'(r_write_slot) < len_now) ? r_write_slot : '0;
    assign n_now = (r_frame_count < len_now) ? r_frame_count : len_now;
    assign need  = (r_min_frames == '0) ? LEN_W'(1) : r_min_frames;
    assign s_tmp = (CNTW + 1)'(cur_p) + (CNTW + 1)'(len_now) - (CNTW + 1)'(n_now);
    assign s0    = (s_tmp >= (CNTW + 1)'(len_now)) ? AW'(s_tmp - (CNTW + 1)'(len_now))
                                                   : AW'(s_tmp);
    assign p_next = ((CNTW'(r_p) + CNTW'(1)) >= r_len) ? '0 : AW'(r_p + 1'b1);
    assign s_next = ((CNTW'(r_s) + CNTW'(1)) >= r_len) ? '0 : AW'(r_s + 1'b1);
    assign i_last = (CNTW'(r_i) == r_len - CNTW'(1));
    assign k_last = (CNTW'(r_k) == r_len - CNTW'(1));
    assign mac_last = ((CNTW'(r_i) + CNTW'(r_k)) == r_len - CNTW'(1));

    always_comb begin
        case (r_band)
            BAND_RED:   band_x = ring_rd.red;
            BAND_GREEN: band_x = ring_rd.green;
            default:    band_x = ring_rd.blue;
        endcase
    end

    assign bin_upd.red   = in_band(r_item.bin_frequency, r_red_lo, r_red_hi) ?
                           sat_add(ring_rd.red, r_item.bin_magnitude) : ring_rd.red;
    assign bin_upd.green = in_band(r_item.bin_frequency, r_green_lo, r_green_hi) ?
                           sat_add(ring_rd.green, r_item.bin_magnitude) : ring_rd.green;
    assign bin_upd.blue  = in_band(r_item.bin_frequency, r_blue_lo, r_blue_hi) ?
                           sat_add(ring_rd.blue, r_item.bin_magnitude) : ring_rd.blue;

    assign xs   = MW'(r_cb_a[ENERGY_W-1:0]) << FRAC_BITS;
    assign cval = (CNTW'(r_i) < r_n) ? $signed({1'b0, xs}) - $signed({1'b0, r_mean}) : '0;
    assign cmag = cval[CW-1] ? MW'(CW'(-cval)) : MW'(cval);
    assign mac_sum = r_acc + LW'(r_prod);
    assign lmag = r_lag_rd[LW-1] ? LW'(-r_lag_rd) : LW'(r_lag_rd);
    assign flat = r_best[LW-1] || (r_best == '0);

    always_comb begin
        if (r_lag_rd[LW-1]) begin
            qval = (div_quo > DDW'(1 << CORR_FRAC)) ? $signed(CORR_W'(1 << CORR_FRAC))
                 : $signed(CORR_W'((CORR_W + 1)'(0) - (CORR_W + 1)'(div_quo)));
        end else begin
            qval = (div_quo > DDW'((1 << CORR_FRAC) - 1)) ?
                   $signed(CORR_W'((1 << CORR_FRAC) - 1)) : $signed(CORR_W'(div_quo));
        end
    end

    always_comb begin
        ring_ctl            = '0;
        ring_ctl.rd_addr    = (r_state == S_IDLE) ? SLOT_W'(cur_p) : SLOT_W'(r_s);
        ring_ctl.wr_addr    = SLOT_W'(r_p);
        ring_ctl.wr_data    = bin_upd;
        ring_ctl.inval_addr = SLOT_W'(p_next);
        ring_ctl.wr_en      = (r_state == S_BIN);
        ring_ctl.inval_en   = (r_state == S_BIN) && r_item.last_bin;
        ring_ctl.clear_all  = accept && (i_item.kind == KIND_CLEAR);
    end

    always_comb begin
        n_state = r_state;       n_ph = r_ph;
        n_i = r_i;  n_k = r_k;   n_s = r_s;   n_p = r_p;
        n_len = r_len;           n_n = r_n;   n_band = r_band;
        n_write_slot = r_write_slot;
        n_frame_count = r_frame_count;
        n_out_valid = 1'b0;      n_out = r_out;
        n_item = r_item;         n_sum = r_sum;   n_mean = r_mean;
        n_maxmag = r_maxmag;     n_mag = r_mag;   n_sh = r_sh;
        n_a = r_a;  n_b = r_b;   n_prod = r_prod;
        n_acc = r_acc;           n_best = r_best;
        cb_we = 1'b0;            cb_wdata = cval;
        lag_we = 1'b0;
        div_start = 1'b0;
        div_dividend = (DDW'(r_sum) << FRAC_BITS) + DDW'(r_n >> 1);
        div_divisor  = LW'(r_n);

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_item = i_item;
                    n_len  = len_now;
                    n_n    = n_now;
                    n_p    = cur_p;
                    n_s    = s0;
                    n_i    = '0;
                    n_k    = '0;
                    n_ph   = PH_ADDR;
                    n_sum  = '0;
                    n_band = i_item.band_select;
                    case (i_item.kind)
                        KIND_BIN: n_state = S_BIN;
                        KIND_REQ: begin
                            if ((LEN_W + 1)'(n_now) < (LEN_W + 1)'(need)) begin
                                n_out_valid = 1'b1;
                                n_out = '0;
                            end else begin
                                n_state = S_LOAD;
                            end
                        end
                        KIND_CLEAR: begin
                            n_write_slot  = '0;
                            n_frame_count = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_BIN: begin
                if (r_item.last_bin) begin
                    n_write_slot = p_next;
                    if (r_frame_count < r_len) begin
                        n_frame_count = r_frame_count + 1'b1;
                    end
                end
                n_state = S_IDLE;
            end
            S_LOAD: begin
                if (r_ph == PH_ADDR) begin
                    n_ph = PH_DATA;
                end else begin
                    cb_we    = 1'b1;
                    cb_wdata = $signed(CW'(band_x));
                    if (CNTW'(r_i) < r_n) begin
                        n_sum = r_sum + SUMW'(band_x);
                    end
                    n_ph = PH_ADDR;
                    n_s  = s_next;
                    if (i_last) begin
                        n_state = S_MEAN;
                    end else begin
                        n_i = r_i + 1'b1;
                    end
                end
            end
            S_MEAN: begin
                if (r_ph == PH_ADDR) begin
                    div_start = 1'b1;
                    n_ph = PH_DATA;
                end else if (div_done) begin
                    n_mean   = MW'(div_quo);
                    n_maxmag = '0;
                    n_i      = '0;
                    n_ph     = PH_ADDR;
                    n_state  = S_CENT;
                end
            end
            S_CENT: begin
                if (r_ph == PH_ADDR) begin
                    n_ph = PH_DATA;
                end else begin
                    cb_we = 1'b1;
                    if (cmag > r_maxmag) begin
                        n_maxmag = cmag;
                    end
                    n_ph = PH_ADDR;
                    if (i_last) begin
                        n_mag   = (cmag > r_maxmag) ? cmag : r_maxmag;
                        n_sh    = '0;
                        n_state = S_SHIFT;
                    end else begin
                        n_i = r_i + 1'b1;
                    end
                end
            end
            S_SHIFT: begin
                if ((r_mag >> NORM_BITS) != '0) begin
                    n_mag = r_mag >> 1;
                    n_sh  = r_sh + 1'b1;
                end else begin
                    n_i = '0;
                    n_k = '0;
                    n_acc = '0;
                    n_ph = PH_ADDR;
                    n_state = S_MAC;
                end
            end
            S_MAC: begin
                case (r_ph)
                    PH_ADDR: n_ph = PH_DATA;
                    PH_DATA: begin
                        n_a  = scale(r_cb_a, r_sh);
                        n_b  = scale(r_cb_b, r_sh);
                        n_ph = PH_MUL;
                    end
                    PH_MUL: begin
                        n_prod = r_a * r_b;
                        n_ph   = PH_ACC;
                    end
                    default: begin
                        n_ph = PH_ADDR;
                        if (mac_last) begin
                            lag_we = 1'b1;
                            if ((r_k == '0) || (mac_sum > r_best)) begin
                                n_best = mac_sum;
                            end
                            n_i   = '0;
                            n_acc = '0;
                            if (k_last) begin
                                n_k = '0;
                                n_state = S_OUT;
                            end else begin
                                n_k = r_k + 1'b1;
                            end
                        end else begin
                            n_acc = mac_sum;
                            n_i   = r_i + 1'b1;
                        end
                    end
                endcase
            end
            S_OUT: begin
                div_dividend = (DDW'(lmag) << CORR_FRAC) + DDW'(r_best[LW-1:1]);
                div_divisor  = LW'(r_best);
                n_out.lag_index     = LAG_W'(r_k);
                n_out.last_lag      = k_last;
                n_out.history_ready = 1'b1;
                n_out.flat_signal   = flat;
                n_out.correlation   = '0;
                case (r_ph)
                    PH_ADDR: n_ph = PH_DATA;
                    PH_DATA: begin
                        if (flat) begin
                            n_out_valid = 1'b1;
                            n_ph = PH_ADDR;
                            if (k_last) begin
                                n_state = S_IDLE;
                            end else begin
                                n_k = r_k + 1'b1;
                            end
                        end else begin
                            div_start = 1'b1;
                            n_ph = PH_MUL;
                        end
                    end
                    default: begin
                        if (div_done) begin
                            n_out_valid = 1'b1;
                            n_out.correlation = qval;
                            n_ph = PH_ADDR;
                            if (k_last) begin
                                n_state = S_IDLE;
                            end else begin
                                n_k = r_k + 1'b1;
                            end
                        end
                    end
                endcase
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_ph          <= PH_ADDR;
            r_i           <= '0;
            r_k           <= '0;
            r_write_slot  <= '0;
            r_frame_count <= '0;
            r_out_valid   <= 1'b0;
            r_red_lo      <= 16'd0;
            r_red_hi      <= 16'd250;
            r_green_lo    <= 16'd251;
            r_green_hi    <= 16'd2000;
            r_blue_lo     <= 16'd2001;
            r_blue_hi     <= 16'd20000;
            r_active_length <= 7'd32;
            r_min_frames  <= 7'd8;
        end else begin
            r_state       <= n_state;
            r_ph          <= n_ph;
            r_i           <= n_i;
            r_k           <= n_k;
            r_write_slot  <= n_write_slot;
            r_frame_count <= n_frame_count;
            r_out_valid   <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_RED_LO:   r_red_lo   <= i_cfg_wdata;
                    REG_RED_HI:   r_red_hi   <= i_cfg_wdata;
                    REG_GREEN_LO: r_green_lo <= i_cfg_wdata;
                    REG_GREEN_HI: r_green_hi <= i_cfg_wdata;
                    REG_BLUE_LO:  r_blue_lo  <= i_cfg_wdata;
                    REG_BLUE_HI:  r_blue_hi  <= i_cfg_wdata;
                    REG_ACT_LEN:  r_active_length <= i_cfg_wdata[LEN_W-1:0];
                    REG_MIN_FRM:  r_min_frames    <= i_cfg_wdata[LEN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s      <= n_s;
        r_p      <= n_p;
        r_len    <= n_len;
        r_n      <= n_n;
        r_band   <= n_band;
        r_item   <= n_item;
        r_sum    <= n_sum;
        r_mean   <= n_mean;
        r_maxmag <= n_maxmag;
        r_mag    <= n_mag;
        r_sh     <= n_sh;
        r_a      <= n_a;
        r_b      <= n_b;
        r_prod   <= n_prod;
        r_acc    <= n_acc;
        r_best   <= n_best;
        r_out    <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (cb_we) begin
            r_cb[r_i] <= cb_wdata;
        end
        r_cb_a <= r_cb[r_i];
        r_cb_b <= r_cb[AW'(r_i + r_k)];
    end

    always_ff @(posedge i_clk) begin
        if (lag_we) begin
            r_lag[r_k] <= mac_sum;
        end
        r_lag_rd <= r_lag[r_k];
    end

    bea_ring #(
        .DEPTH (DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ring_ctl),
        .o_rd_data (ring_rd)
    );

    bea_divider #(
        .DDW (DDW),
        .DSW (LW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

    a_not_ready_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_result.history_ready) |->
            (o_result.lag_index == '0 && o_result.correlation == '0 && !o_result.last_lag))
        else $error("not-ready result carries nonzero fields");

    a_flat_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.flat_signal) |-> (o_result.correlation == '0))
        else $error("flat history gave nonzero correlation");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.last_lag) |-> !busy)
        else $error("sequencer still busy after final lag");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CNTW + 1)'(r_frame_count) <= (CNTW + 1)'(DEPTH))
        else $error("frame count beyond ring depth");

    a_no_result_while_bin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BIN) |=> !o_result_valid)
        else $error("spectrum bin transaction produced a result");

endmodule
